// File: design/hmr_pkg.sv
package hmr_pkg;

    // Result area width and the value it saturates at.
    localparam int AREA_W = 26;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_POP,
        ST_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_bar;
        logic load_close;
        logic set_ovf;
        logic pop_issue;
        logic pop_finish;
        logic replace;
        logic push;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_full;
        logic top_pop;
        logic top_eq;
        logic out_busy;
    } t_sts;

endpackage

// File: design/hmr_ram.sv
module hmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/hmr_ctrl.sv
module hmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_stall,
    input  hmr_pkg::t_sts i_sts,
    output hmr_pkg::t_cmd o_cmd
);

    hmr_pkg::t_state r_state, n_state;
    logic            r_last, n_last;
    logic            r_closing, n_closing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hmr_pkg::ST_IDLE;
            r_last    <= 1'b0;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_closing <= n_closing;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        n_closing  = r_closing;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            hmr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (!i_sts.count_full) begin
                        o_cmd.load_bar = 1'b1;
                        n_last         = i_last;
                        n_closing      = 1'b0;
                        n_state        = hmr_pkg::ST_CMP;
                    end else begin
                        // An extra bar is dropped; a last flag still closes.
                        o_cmd.set_ovf = 1'b1;
                        if (i_last) begin
                            o_cmd.load_close = 1'b1;
                            n_last           = 1'b1;
                            n_closing        = 1'b1;
                            n_state          = hmr_pkg::ST_CMP;
                        end
                    end
                end
            end
            hmr_pkg::ST_CMP: begin
                if (i_sts.top_pop) begin
                    o_cmd.pop_issue = 1'b1;
                    n_state         = hmr_pkg::ST_POP;
                end else if (r_closing) begin
                    n_state = hmr_pkg::ST_FLUSH;
                end else begin
                    if (i_sts.top_eq) begin
                        o_cmd.replace = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                    if (r_last) begin
                        o_cmd.load_close = 1'b1;
                        n_closing        = 1'b1;
                    end else begin
                        n_state = hmr_pkg::ST_IDLE;
                    end
                end
            end
            hmr_pkg::ST_POP: begin
                o_cmd.pop_finish = 1'b1;
                n_state          = hmr_pkg::ST_CMP;
            end
            hmr_pkg::ST_FLUSH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_last     = 1'b0;
                    n_closing  = 1'b0;
                    n_state    = hmr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hmr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/hmr_dpath.sv
module hmr_dpath #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [15:0]                 i_height,
    input  hmr_pkg::t_cmd               i_cmd,
    output hmr_pkg::t_sts               o_sts,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [hmr_pkg::AREA_W-1:0]  o_max_area,
    output logic                        o_overflow
);

    localparam int POS_W  = $clog2(MAX_BARS + 2);
    localparam int TOP_W  = $clog2(MAX_BARS + 1);
    localparam int ADDR_W = $clog2(MAX_BARS);
    localparam int PROD_W = HEIGHT_BITS + POS_W;
    localparam int ENT_W  = HEIGHT_BITS + POS_W;

    // Cached top of stack; the RAM holds every entry below it.
    logic [TOP_W-1:0]       r_top;
    logic [HEIGHT_BITS-1:0] r_top_h;
    logic [POS_W-1:0]       r_top_pos;
    logic [POS_W-1:0]       r_count;
    logic [hmr_pkg::AREA_W-1:0] r_best;
    logic                   r_ovf;

    // Bar being applied.
    logic [HEIGHT_BITS-1:0] r_cur_h;
    logic [POS_W-1:0]       r_cur_pos;

    // Score pipeline: width, then product, then fold into the maximum.
    logic [HEIGHT_BITS-1:0] r_pop_h;
    logic [POS_W-1:0]       r_width;
    logic                   r_wvld;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_pvld;

    logic                   r_ovalid;
    logic [hmr_pkg::AREA_W-1:0] r_oarea;
    logic                   r_oovf;

    logic [HEIGHT_BITS-1:0] w_height;
    logic [TOP_W-1:0]       w_top_m1;
    logic [ENT_W-1:0]       w_rdata;
    logic [HEIGHT_BITS-1:0] w_rd_h;
    logic [POS_W-1:0]       w_rd_pos;
    logic [63:0]            w_prod_ext;
    logic [hmr_pkg::AREA_W-1:0] w_sat;
    logic [hmr_pkg::AREA_W-1:0] n_best;

    assign w_height = HEIGHT_BITS'({16'd0, i_height});
    assign w_top_m1 = r_top - TOP_W'(1);
    assign w_rd_h   = w_rdata[ENT_W-1:POS_W];
    assign w_rd_pos = w_rdata[POS_W-1:0];

    hmr_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_BARS)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_waddr(r_top[ADDR_W-1:0]),
        .i_wdata({r_top_h, r_top_pos}),
        .i_re   (i_cmd.pop_issue),
        .i_raddr(w_top_m1[ADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_prod_ext = {{(64 - PROD_W){1'b0}}, r_prod};
        w_sat      = (w_prod_ext > 64'(hmr_pkg::AREA_MAX)) ? hmr_pkg::AREA_MAX
                                                           : hmr_pkg::AREA_W'(w_prod_ext);
        n_best     = (r_pvld && (w_sat > r_best)) ? w_sat : r_best;
    end

    always_comb begin
        o_sts.count_full = (r_count == POS_W'(MAX_BARS));
        o_sts.top_pop    = (r_top != '0) && (r_top_h > r_cur_h);
        o_sts.top_eq     = (r_top_h == r_cur_h);
        o_sts.out_busy   = r_ovalid && i_out_stall;
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bar) begin
            r_cur_h   <= w_height;
            r_cur_pos <= r_count + POS_W'(1);
        end else if (i_cmd.load_close) begin
            r_cur_h   <= '0;
            r_cur_pos <= r_count + POS_W'(1);
        end
        if (i_cmd.pop_issue) begin
            r_pop_h <= r_top_h;
        end
        if (i_cmd.pop_finish) begin
            r_width <= r_cur_pos - w_rd_pos - POS_W'(1);
        end
        if (r_wvld) begin
            r_prod <= PROD_W'(r_pop_h) * PROD_W'(r_width);
        end
        if (i_cmd.emit) begin
            r_oarea <= n_best;
            r_oovf  <= r_ovf;
        end
    end

    // Control and stack state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_top_h   <= '0;
            r_top_pos <= '0;
            r_count   <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
            r_wvld    <= 1'b0;
            r_pvld    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_top     <= '0;
            r_top_h   <= '0;
            r_top_pos <= '0;
            r_count   <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
            r_wvld    <= 1'b0;
            r_pvld    <= 1'b0;
            r_ovalid  <= 1'b1;
        end else begin
            r_best <= n_best;
            r_wvld <= i_cmd.pop_finish;
            r_pvld <= r_wvld;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.load_bar) begin
                r_count <= r_count + POS_W'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.pop_finish) begin
                r_top     <= w_top_m1;
                r_top_h   <= w_rd_h;
                r_top_pos <= w_rd_pos;
            end else if (i_cmd.replace) begin
                r_top_pos <= r_cur_pos;
            end else if (i_cmd.push) begin
                r_top     <= r_top + TOP_W'(1);
                r_top_h   <= r_cur_h;
                r_top_pos <= r_cur_pos;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_max_area  = r_oarea;
    assign o_overflow  = r_oovf;

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_finish |-> (r_top != '0))
        else $error("pop completed on an empty stack");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_top < TOP_W'(MAX_BARS)))
        else $error("push beyond stack depth");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_wvld)
        else $error("result emitted with a score still in flight");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (o_out_valid && (r_best == '0) && (r_top == '0)
                        && (r_count == '0)))
        else $error("state not cleared after result");

    a_top_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_finish |=> (r_top_h < $past(r_top_h)))
        else $error("stack heights not strictly increasing");
`endif

endmodule

// File: design/histogram_max_rectangle_stack.sv
// Channel   Direction  Handshake                  Payload per beat
// in        to block   i_in_valid / o_in_stall    i_height[15:0], i_last
// out       from block o_out_valid / i_out_stall  o_max_area[25:0], o_overflow
//
// A bar is accepted, then compared: each taller entry is popped by a compare
// and a pop step, as each pop waits on the stack RAM read; then the bar is
// pushed or replaces an equal top. The last bar adds the closing pass (popping
// the remaining entries, then a compare) and a flush step to hand over the result.
// Reset is synchronous and active low; the stack RAM needs no clearing pass.
// A stalled result waits in the output register and holds only the next close.
module histogram_max_rectangle_stack #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [15:0]                i_height,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [hmr_pkg::AREA_W-1:0] o_max_area,
    output logic                       o_overflow
);

    // The controller sequences compare, pop and flush steps; the datapath
    // holds the stack, the bar counter and the scoring pipeline.
    hmr_pkg::t_cmd w_cmd;
    hmr_pkg::t_sts w_sts;

    hmr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_last    (i_last),
        .o_in_stall(o_in_stall),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Scores flow width, product, then maximum over three registers. The flush
    // step comes after the last pop with at least the compare state between, so the last product is
    // folded into the maximum as the result is captured.
    hmr_dpath #(
        .MAX_BARS   (MAX_BARS),
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_height   (i_height),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_max_area (o_max_area),
        .o_overflow (o_overflow)
    );

endmodule
